// File: rtl/cpu8080_alu_register_executor_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 8080 ALU/register executor
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef CPU8080_ALU_REGISTER_EXECUTOR_ASSERT_SVH
`define CPU8080_ALU_REGISTER_EXECUTOR_ASSERT_SVH
`ifndef SYNTH
`define C80_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define C80_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define C80_ASSERT_IMP(label, clk, rst_n, a, c)
`define C80_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/c80_pkg.sv
// ----------------------------------------------------------------------------
// c80_pkg
// Types, codes and flag helpers shared by the 8080 executor.
// ----------------------------------------------------------------------------
package c80_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  opcode;
    logic [15:0] mem_address;
    logic [7:0]  write_byte;
  } c80_in_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  flags_out;
    logic [7:0]  b_out;
    logic [7:0]  c_out;
    logic [7:0]  d_out;
    logic [7:0]  e_out;
    logic [7:0]  h_out;
    logic [7:0]  l_out;
    logic [15:0] pc_out;
    logic [7:0]  read_byte;
  } c80_out_t;

  localparam logic [1:0] MODE_EXEC  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_FETCH = 2'd3;

  localparam logic [7:0] FLAGS_RESET = 8'b00000010;
  localparam logic [7:0] LO_MASK     = 8'h0F;
  localparam logic [7:0] HI_CORR     = 8'h60;

  localparam logic [7:0] OP_CMC  = 8'h3F;
  localparam logic [7:0] OP_STC  = 8'h37;
  localparam logic [7:0] OP_CMA  = 8'h2F;
  localparam logic [7:0] OP_DAA  = 8'h27;
  localparam logic [7:0] OP_STAXB = 8'h02;
  localparam logic [7:0] OP_STAXD = 8'h12;
  localparam logic [7:0] OP_LDAXB = 8'h0A;
  localparam logic [7:0] OP_LDAXD = 8'h1A;
  localparam logic [7:0] OP_HLT  = 8'h76;

  localparam logic [2:0] SEL_M = 3'd6;
  localparam logic [2:0] SEL_A = 3'd7;

  // ALU operations of the shared unit
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_SBB = 3'd3;
  localparam logic [2:0] ALU_ANA = 3'd4;
  localparam logic [2:0] ALU_XRA = 3'd5;
  localparam logic [2:0] ALU_ORA = 3'd6;
  localparam logic [2:0] ALU_CMP = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] a;
    logic [7:0] b;
    logic       cy;
  } c80_alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic [7:0] flags;
  } c80_alu_rsp_t;

  function automatic logic [7:0] szp(input logic [7:0] r);
    szp = {r[7], (r == 8'd0), 1'b0, 1'b0, 1'b0, ~^r, 1'b1, 1'b0};
  endfunction

endpackage

// File: rtl/c80_ram.sv
// ----------------------------------------------------------------------------
// c80_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module c80_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/c80_alu.sv
// ----------------------------------------------------------------------------
// c80_alu
// Shared 8-bit arithmetic/logic unit with 8080 flag generation.
// ----------------------------------------------------------------------------
module c80_alu (
  input  c80_pkg::c80_alu_req_t req,
  output c80_pkg::c80_alu_rsp_t rsp
);
  import c80_pkg::*;

  logic       sub;
  logic [7:0] bx;
  logic       cin;
  logic [8:0] sum;
  logic [7:0] r;
  logic       ac;

  always_comb begin
    sub = (req.op == ALU_SUB) || (req.op == ALU_SBB) || (req.op == ALU_CMP);
    bx  = sub ? ~req.b : req.b;
    unique case (req.op)
      ALU_ADC: cin = req.cy;
      ALU_SUB, ALU_CMP: cin = 1'b1;
      ALU_SBB: cin = ~req.cy;
      default: cin = 1'b0;
    endcase
    sum = {1'b0, req.a} + {1'b0, bx} + {8'd0, cin};
    ac  = req.a[4] ^ bx[4] ^ sum[4];
    unique case (req.op)
      ALU_ANA: begin
        r = req.a & req.b;
        rsp.flags = szp(r) | {3'b000, req.a[3] | req.b[3], 4'b0000};
      end
      ALU_XRA: begin
        r = req.a ^ req.b;
        rsp.flags = szp(r);
      end
      ALU_ORA: begin
        r = req.a | req.b;
        rsp.flags = szp(r);
      end
      default: begin
        r = sum[7:0];
        rsp.flags = szp(r) | {3'b000, ac, 3'b000, sum[8] ^ sub};
      end
    endcase
    rsp.res = r;
  end
endmodule

// File: rtl/cpu8080_alu_register_executor.sv
// ----------------------------------------------------------------------------
// cpu8080_alu_register_executor
// Executes 8080 register/ALU opcodes and memory modes through a sequencer.
// ----------------------------------------------------------------------------
// channel | ports                          | direction
// input   | in_valid/in_stall/in_data      | in
// result  | out_valid/out_stall/out_data   | out
// A write passes MWAIT and OUT; a read passes MWAIT, EXEC and OUT. A fetch
// first issues the registered read at pc in FWAIT; every opcode then passes a
// decode state, an operand read state (used or not) and an execute state; the
// result then sits in the output register and is held while out_stall is high.
// A new transaction is taken only once the previous result has been taken.
// Reset clears registers to zero, flags to 0x02; memory is not cleared.
module cpu8080_alu_register_executor #(
  parameter int ADDR_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  c80_pkg::c80_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output c80_pkg::c80_out_t out_data
);
  import c80_pkg::*;
  `include "cpu8080_alu_register_executor_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FWAIT = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_MWAIT = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [7:0]  a_r, a_nxt, f_r, f_nxt;
  logic [7:0]  b_r, b_nxt, c_r, c_nxt, d_r, d_nxt, e_r, e_nxt, h_r, h_nxt, l_r, l_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  op_r, op_nxt, rb_r, rb_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  wb_r, wb_nxt;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [7:0]           mem_wdata, mem_rdata;

  c80_alu_req_t alu_req;
  c80_alu_rsp_t alu_rsp;

  c80_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  c80_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  logic [2:0]  src, dst;
  logic        needs_m;
  logic [7:0]  srcv, dstv, incdec, corr;
  logic [7:0]  lo, hi;
  logic [15:0] bc_pair, de_pair, hl_pair;

  function automatic logic [7:0] reg_rd(input logic [2:0] s, input logic [7:0] a,
    input logic [7:0] b, input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
    input logic [7:0] h, input logic [7:0] l, input logic [7:0] m);
    unique case (s)
      3'd0: reg_rd = b;
      3'd1: reg_rd = c;
      3'd2: reg_rd = d;
      3'd3: reg_rd = e;
      3'd4: reg_rd = h;
      3'd5: reg_rd = l;
      SEL_M: reg_rd = m;
      default: reg_rd = a;
    endcase
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{acc_out: a_r, flags_out: f_r, b_out: b_r, c_out: c_r, d_out: d_r,
                       e_out: e_r, h_out: h_r, l_out: l_r, pc_out: pc_r, read_byte: rb_r};

  always_comb begin
    bc_pair = {b_r, c_r};
    de_pair = {d_r, e_r};
    hl_pair = {h_r, l_r};
    src = op_r[2:0];
    dst = op_r[5:3];
    // memory operand needed before execution
    needs_m = (op_r[7] && src == SEL_M) ||
              (op_r[7:6] == 2'b01 && src == SEL_M && op_r != OP_HLT) ||
              (op_r[7:6] == 2'b00 && (src == 3'd4 || src == 3'd5) && dst == SEL_M) ||
              (op_r == OP_LDAXB) || (op_r == OP_LDAXD);
    srcv = reg_rd(src, a_r, b_r, c_r, d_r, e_r, h_r, l_r, mem_rdata);
    dstv = reg_rd(dst, a_r, b_r, c_r, d_r, e_r, h_r, l_r, mem_rdata);
    lo = {4'd0, a_r[3:0]};
    hi = {4'd0, a_r[7:4]};
    corr = 8'd0;
    if (lo > 8'd9 || f_r[4]) corr = corr | 8'h06;
    if (f_r[0] || hi > 8'd9 || (hi >= 8'd9 && lo > 8'd9)) corr = corr | HI_CORR;
    incdec = src[0] ? dstv - 8'd1 : dstv + 8'd1;

    alu_req.op = op_r[7] ? dst : ALU_ADD;
    alu_req.a  = a_r;
    alu_req.b  = op_r[7] ? srcv : corr;
    alu_req.cy = f_r[0];

    state_nxt = state_r;
    a_nxt = a_r; f_nxt = f_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    h_nxt = h_r; l_nxt = l_r; pc_nxt = pc_r; op_nxt = op_r; rb_nxt = rb_r;
    mode_nxt = mode_r; addr_nxt = addr_r; wb_nxt = wb_r;
    mem_we = 1'b0;
    mem_addr = addr_r[ADDR_BITS-1:0];
    mem_wdata = wb_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_data.mode;
          op_nxt   = in_data.opcode;
          addr_nxt = in_data.mem_address;
          wb_nxt   = in_data.write_byte;
          rb_nxt   = 8'd0;
          unique case (in_data.mode)
            MODE_EXEC:  state_nxt = S_DEC;
            MODE_FETCH: begin
              addr_nxt  = pc_r;
              state_nxt = S_FWAIT;
            end
            default: state_nxt = S_MWAIT;
          endcase
        end
      end
      S_FWAIT: begin
        // issue fetch read; data arrives next cycle
        mem_addr = pc_r[ADDR_BITS-1:0];
        pc_nxt = pc_r + 16'd1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (mode_r == MODE_FETCH) op_nxt = mem_rdata;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (mode_r == MODE_WRITE) begin
          mem_we = 1'b1;
          state_nxt = S_OUT;
        end else if (mode_r == MODE_READ) begin
          state_nxt = S_EXEC;
        end else begin
          if (op_r == OP_LDAXB) mem_addr = bc_pair[ADDR_BITS-1:0];
          else if (op_r == OP_LDAXD) mem_addr = de_pair[ADDR_BITS-1:0];
          else mem_addr = hl_pair[ADDR_BITS-1:0];
          state_nxt = needs_m ? S_EXEC : S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        mem_addr = hl_pair[ADDR_BITS-1:0];
        if (mode_r == MODE_READ) begin
          rb_nxt = mem_rdata;
        end else if (op_r[7]) begin
          if (dst != ALU_CMP) a_nxt = alu_rsp.res;
          f_nxt = alu_rsp.flags;
        end else if (op_r[6]) begin
          if (op_r != OP_HLT) begin
            unique case (dst)
              3'd0: b_nxt = srcv;
              3'd1: c_nxt = srcv;
              3'd2: d_nxt = srcv;
              3'd3: e_nxt = srcv;
              3'd4: h_nxt = srcv;
              3'd5: l_nxt = srcv;
              SEL_M: begin
                mem_we = 1'b1;
                mem_wdata = srcv;
              end
              default: a_nxt = srcv;
            endcase
          end
        end else if (src == 3'd4 || src == 3'd5) begin
          unique case (dst)
            3'd0: b_nxt = incdec;
            3'd1: c_nxt = incdec;
            3'd2: d_nxt = incdec;
            3'd3: e_nxt = incdec;
            3'd4: h_nxt = incdec;
            3'd5: l_nxt = incdec;
            SEL_M: begin
              mem_we = 1'b1;
              mem_wdata = incdec;
            end
            default: a_nxt = incdec;
          endcase
          f_nxt = szp(incdec) | {3'b000,
                  src[0] ? ((incdec & LO_MASK) != LO_MASK) : ((incdec & LO_MASK) == 8'd0),
                  3'b000, f_r[0]};
        end else begin
          priority case (op_r)
            OP_CMC: f_nxt = f_r ^ 8'h01;
            OP_STC: f_nxt = f_r | 8'h01;
            OP_CMA: a_nxt = ~a_r;
            OP_DAA: begin
              a_nxt = alu_rsp.res;
              f_nxt = {alu_rsp.flags[7:1], f_r[0] | corr[6]};
            end
            OP_STAXB: begin
              mem_addr = bc_pair[ADDR_BITS-1:0];
              mem_we = 1'b1;
              mem_wdata = a_r;
            end
            OP_STAXD: begin
              mem_addr = de_pair[ADDR_BITS-1:0];
              mem_we = 1'b1;
              mem_wdata = a_r;
            end
            OP_LDAXB, OP_LDAXD: a_nxt = mem_rdata;
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_r <= 8'd0; f_r <= FLAGS_RESET;
      b_r <= 8'd0; c_r <= 8'd0; d_r <= 8'd0; e_r <= 8'd0; h_r <= 8'd0; l_r <= 8'd0;
      pc_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      a_r <= a_nxt; f_r <= f_nxt;
      b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt; h_r <= h_nxt; l_r <= l_nxt;
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; rb_r <= rb_nxt; mode_r <= mode_nxt; addr_r <= addr_nxt; wb_r <= wb_nxt;
  end

  `C80_ASSERT_IMP(a_flag_one, clk, rst_n, 1'b1, f_r[1] && !f_r[3] && !f_r[5])
  `C80_ASSERT_NXT(a_take_busy, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE)
  `C80_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `C80_ASSERT_IMP(a_rb_zero, clk, rst_n, out_valid && mode_r != MODE_READ, rb_r == 8'd0)
endmodule
